### hdl/rotation_matrix_to_quaternion_top_defines.svh
// Assertion macros shared by the rotation matrix to quaternion block.
`ifndef ROTATION_MATRIX_TO_QUATERNION_TOP_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_TOP_DEFINES_SVH

// Check a property on every rising clock edge outside reset.
`define RMQ_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("rmq assertion failed");

// Check that a condition never holds.
`define RMQ_NEVER(lbl, expr) \
	`RMQ_ASSERT(lbl, !(expr))

`endif

### hdl/rmq_pkg.sv
// Package with widths, codes and types of the rotation matrix to quaternion block.
`timescale 1ns / 1ps
package rmq_pkg;
	localparam int FRAC_BITS = 16;
	localparam int FW = 18;
	localparam int R_W = ((FW + 1 > FRAC_BITS) ? FW + 1 : FRAC_BITS) + 1;
	localparam int CW = R_W + 1;
	localparam int X_W = R_W + FRAC_BITS;
	localparam int SQ_STEPS = (X_W + 1) / 2;
	localparam int X_PAD = 2 * SQ_STEPS;
	localparam int S_W = SQ_STEPS;
	localparam int SR_W = S_W + 3;
	localparam int D_W = FW + 1;
	localparam int M_W = FW + 1;
	localparam int Q_W = FW;
	localparam int N_W = M_W + FRAC_BITS + 1;
	localparam int P_W = ((N_W > S_W + 1 + Q_W) ? N_W : S_W + 1 + Q_W) + 1;
	localparam int FIFO_DEPTH = 2;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int LATENCY = 4 + SQ_STEPS + Q_W;

	localparam logic [FW-1:0] OUT_MAX = {1'b0, {(FW-1){1'b1}}};
	localparam logic [FW-1:0] OUT_MIN = {1'b1, {(FW-1){1'b0}}};

	localparam logic [1:0] BR_TRACE = 2'd0;
	localparam logic [1:0] BR_X = 2'd1;
	localparam logic [1:0] BR_Y = 2'd2;
	localparam logic [1:0] BR_Z = 2'd3;

	localparam logic [1:0] C_X = 2'd0;
	localparam logic [1:0] C_Y = 2'd1;
	localparam logic [1:0] C_Z = 2'd2;
	localparam logic [1:0] C_W = 2'd3;

	typedef struct packed {
		logic [1:0] br;
		logic degen;
		logic [R_W-1:0] r;
		logic [3:0] neg;
		logic [3:0][M_W-1:0] mag;
	} front_t;
endpackage

### hdl/rmq_front.sv
// Front end: accepts a matrix, selects the branch and forms radicand and numerators.
`timescale 1ns / 1ps
module rmq_front (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic signed [rmq_pkg::FW-1:0] m11,
	input logic signed [rmq_pkg::FW-1:0] m12,
	input logic signed [rmq_pkg::FW-1:0] m13,
	input logic signed [rmq_pkg::FW-1:0] m21,
	input logic signed [rmq_pkg::FW-1:0] m22,
	input logic signed [rmq_pkg::FW-1:0] m23,
	input logic signed [rmq_pkg::FW-1:0] m31,
	input logic signed [rmq_pkg::FW-1:0] m32,
	input logic signed [rmq_pkg::FW-1:0] m33,
	output logic out_v,
	output rmq_pkg::front_t out_d
);
	localparam int CW = rmq_pkg::CW;
	localparam int D_W = rmq_pkg::D_W;

	logic signed [CW-1:0] e11, e12, e13, e21, e22, e23, e31, e32, e33;
	logic signed [CW-1:0] one, trace, r_full;
	logic signed [D_W-1:0] dv [4];
	logic [1:0] br;
	rmq_pkg::front_t nd;
	logic front_v_s1;
	rmq_pkg::front_t front_d_s1;

	always_comb begin
		e11 = CW'(m11); e12 = CW'(m12); e13 = CW'(m13);
		e21 = CW'(m21); e22 = CW'(m22); e23 = CW'(m23);
		e31 = CW'(m31); e32 = CW'(m32); e33 = CW'(m33);
		one = CW'(1) <<< rmq_pkg::FRAC_BITS;
		trace = e11 + e22 + e33;
		if (trace > 0) begin
			br = rmq_pkg::BR_TRACE;
			r_full = trace + one;
		end else if (e11 >= e22 && e11 >= e33) begin
			br = rmq_pkg::BR_X;
			r_full = one + e11 - e22 - e33;
		end else if (e22 > e33) begin
			br = rmq_pkg::BR_Y;
			r_full = one + e22 - e11 - e33;
		end else begin
			br = rmq_pkg::BR_Z;
			r_full = one + e33 - e11 - e22;
		end
		for (int c = 0; c < 4; c++) dv[c] = '0;
		case (br)
			rmq_pkg::BR_TRACE: begin
				dv[rmq_pkg::C_X] = D_W'(e23 - e32);
				dv[rmq_pkg::C_Y] = D_W'(e31 - e13);
				dv[rmq_pkg::C_Z] = D_W'(e12 - e21);
			end
			rmq_pkg::BR_X: begin
				dv[rmq_pkg::C_Y] = D_W'(e12 + e21);
				dv[rmq_pkg::C_Z] = D_W'(e13 + e31);
				dv[rmq_pkg::C_W] = D_W'(e23 - e32);
			end
			rmq_pkg::BR_Y: begin
				dv[rmq_pkg::C_X] = D_W'(e21 + e12);
				dv[rmq_pkg::C_Z] = D_W'(e32 + e23);
				dv[rmq_pkg::C_W] = D_W'(e31 - e13);
			end
			default: begin
				dv[rmq_pkg::C_X] = D_W'(e31 + e13);
				dv[rmq_pkg::C_Y] = D_W'(e32 + e23);
				dv[rmq_pkg::C_W] = D_W'(e12 - e21);
			end
		endcase
		nd.br = br;
		nd.degen = (r_full <= 0);
		nd.r = r_full[rmq_pkg::R_W-1:0];
		for (int c = 0; c < 4; c++) begin
			nd.neg[c] = dv[c][D_W-1];
			nd.mag[c] = dv[c][D_W-1] ? unsigned'(-dv[c]) : unsigned'(dv[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_v_s1 <= 1'b0;
		end else begin
			front_v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			front_d_s1 <= nd;
		end
	end

	assign out_v = front_v_s1;
	assign out_d = front_d_s1;
endmodule

### hdl/rmq_fifo.sv
// Short queue between the front end and the arithmetic back end.
`timescale 1ns / 1ps
module rmq_fifo (
	input logic clk,
	input logic arst_n,
	input logic push,
	input rmq_pkg::front_t in_d,
	input logic pop,
	output logic full,
	output logic empty,
	output rmq_pkg::front_t out_d
);
	localparam int PTR_W = rmq_pkg::PTR_W;

	rmq_pkg::front_t mem [rmq_pkg::FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [PTR_W:0] cnt_q;
	logic do_push, do_pop;

	assign full = (cnt_q == (PTR_W+1)'(rmq_pkg::FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign do_pop = pop && !empty;
	assign do_push = push && (!full || do_pop);
	assign out_d = mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_q] <= in_d;
		end
	end
endmodule

### hdl/rmq_back.sv
// Back end: pipelined square root, four pipelined dividers and output saturation.
`timescale 1ns / 1ps
module rmq_back (
	input logic clk,
	input logic arst_n,
	input logic in_v,
	input rmq_pkg::front_t in_d,
	output logic done,
	output logic signed [rmq_pkg::FW-1:0] qx,
	output logic signed [rmq_pkg::FW-1:0] qy,
	output logic signed [rmq_pkg::FW-1:0] qz,
	output logic signed [rmq_pkg::FW-1:0] qw,
	output logic [1:0] branch_taken,
	output logic degenerate
);
	localparam int SQ_STEPS = rmq_pkg::SQ_STEPS;
	localparam int X_PAD = rmq_pkg::X_PAD;
	localparam int S_W = rmq_pkg::S_W;
	localparam int SR_W = rmq_pkg::SR_W;
	localparam int Q_W = rmq_pkg::Q_W;
	localparam int P_W = rmq_pkg::P_W;
	localparam int FW = rmq_pkg::FW;

	typedef struct packed {
		rmq_pkg::front_t f;
		logic [X_PAD-1:0] x;
		logic [SR_W-1:0] rem;
		logic [S_W-1:0] root;
	} sq_t;

	typedef struct packed {
		rmq_pkg::front_t f;
		logic [S_W:0] dv;
		logic [S_W-1:0] big;
		logic [3:0] ovf;
		logic [3:0][P_W-1:0] p;
		logic [3:0][Q_W-1:0] q;
	} dv_t;

	function automatic logic [1:0] big_comp(input logic [1:0] br);
		case (br)
			rmq_pkg::BR_TRACE: big_comp = rmq_pkg::C_W;
			rmq_pkg::BR_X: big_comp = rmq_pkg::C_X;
			rmq_pkg::BR_Y: big_comp = rmq_pkg::C_Y;
			default: big_comp = rmq_pkg::C_Z;
		endcase
	endfunction

	function automatic logic [FW-1:0] clamp(input logic neg, input logic ovf,
			input logic [Q_W-1:0] m);
		logic [Q_W:0] t;
		t = (Q_W+1)'(0) - {1'b0, m};
		if (neg) begin
			clamp = (ovf || m > Q_W'(rmq_pkg::OUT_MIN)) ? rmq_pkg::OUT_MIN : t[FW-1:0];
		end else begin
			clamp = (ovf || m > Q_W'(rmq_pkg::OUT_MAX)) ? rmq_pkg::OUT_MAX : FW'(m);
		end
	endfunction

	sq_t sq [0:SQ_STEPS];
	logic sq_v [0:SQ_STEPS];
	dv_t dq [0:Q_W];
	logic dq_v [0:Q_W];

	logic done_q, degen_q;
	logic [1:0] br_q;
	logic [FW-1:0] res_q [4];

	always_comb begin
		sq_v[0] = in_v;
		sq[0].f = in_d;
		sq[0].x = X_PAD'(in_d.r) << rmq_pkg::FRAC_BITS;
		sq[0].rem = '0;
		sq[0].root = '0;
	end

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
		logic [SR_W-1:0] bring, trial;
		sq_t nx;
		always_comb begin
			bring = {sq[k].rem[SR_W-3:0], sq[k].x[X_PAD-1 -: 2]};
			trial = SR_W'({sq[k].root, 2'b01});
			nx.f = sq[k].f;
			nx.x = sq[k].x << 2;
			if (bring >= trial) begin
				nx.rem = bring - trial;
				nx.root = {sq[k].root[S_W-2:0], 1'b1};
			end else begin
				nx.rem = bring;
				nx.root = {sq[k].root[S_W-2:0], 1'b0};
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_v[k+1] <= 1'b0;
			else sq_v[k+1] <= sq_v[k];
		end
		always_ff @(posedge clk) begin
			sq[k+1] <= nx;
		end
	end

	dv_t prep;
	logic [P_W-1:0] lim;
	always_comb begin
		prep.f = sq[SQ_STEPS].f;
		prep.dv = {sq[SQ_STEPS].root, 1'b0};
		prep.big = sq[SQ_STEPS].root >> 1;
		lim = P_W'(prep.dv) << Q_W;
		for (int c = 0; c < 4; c++) begin
			prep.p[c] = (P_W'(sq[SQ_STEPS].f.mag[c]) << rmq_pkg::FRAC_BITS)
				+ P_W'(sq[SQ_STEPS].root);
			prep.ovf[c] = (prep.p[c] >= lim);
			prep.q[c] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dq_v[0] <= 1'b0;
		else dq_v[0] <= sq_v[SQ_STEPS];
	end
	always_ff @(posedge clk) begin
		dq[0] <= prep;
	end

	for (genvar k = 0; k < Q_W; k++) begin : g_div
		logic [P_W-1:0] dlim;
		dv_t nx;
		always_comb begin
			dlim = P_W'(dq[k].dv) << (Q_W - 1);
			nx = dq[k];
			for (int c = 0; c < 4; c++) begin
				if (dq[k].p[c] >= dlim) begin
					nx.p[c] = (dq[k].p[c] - dlim) << 1;
					nx.q[c] = {dq[k].q[c][Q_W-2:0], 1'b1};
				end else begin
					nx.p[c] = dq[k].p[c] << 1;
					nx.q[c] = {dq[k].q[c][Q_W-2:0], 1'b0};
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dq_v[k+1] <= 1'b0;
			else dq_v[k+1] <= dq_v[k];
		end
		always_ff @(posedge clk) begin
			dq[k+1] <= nx;
		end
	end

	logic [FW-1:0] res_d [4];
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			if (dq[Q_W].f.degen) res_d[c] = '0;
			else if (2'(c) == big_comp(dq[Q_W].f.br))
				res_d[c] = clamp(1'b0, 1'b0, Q_W'(dq[Q_W].big));
			else res_d[c] = clamp(dq[Q_W].f.neg[c], dq[Q_W].ovf[c], dq[Q_W].q[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= dq_v[Q_W];
	end

	always_ff @(posedge clk) begin
		br_q <= dq[Q_W].f.br;
		degen_q <= dq[Q_W].f.degen;
		for (int c = 0; c < 4; c++) res_q[c] <= res_d[c];
	end

	assign done = done_q;
	assign qx = signed'(res_q[rmq_pkg::C_X]);
	assign qy = signed'(res_q[rmq_pkg::C_Y]);
	assign qz = signed'(res_q[rmq_pkg::C_Z]);
	assign qw = signed'(res_q[rmq_pkg::C_W]);
	assign branch_taken = br_q;
	assign degenerate = degen_q;
endmodule

### hdl/rotation_matrix_to_quaternion_top.sv
// Top level of the rotation matrix to quaternion converter.
// Pipeline: front register, queue entry, 18 square root stages, one numerator stage,
// 18 divider stages and output register; done rises with the registered result.
// Throughput: one matrix per cycle while busy is low; the square root and divider pipelines never stall.
// Reset: arst_n clears all valid bits and the queue at once; no transaction survives it.
`timescale 1ns / 1ps
`include "rotation_matrix_to_quaternion_top_defines.svh"
module rotation_matrix_to_quaternion_top (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic signed [rmq_pkg::FW-1:0] m11,
	input logic signed [rmq_pkg::FW-1:0] m12,
	input logic signed [rmq_pkg::FW-1:0] m13,
	input logic signed [rmq_pkg::FW-1:0] m21,
	input logic signed [rmq_pkg::FW-1:0] m22,
	input logic signed [rmq_pkg::FW-1:0] m23,
	input logic signed [rmq_pkg::FW-1:0] m31,
	input logic signed [rmq_pkg::FW-1:0] m32,
	input logic signed [rmq_pkg::FW-1:0] m33,
	output logic done,
	output logic signed [rmq_pkg::FW-1:0] qx,
	output logic signed [rmq_pkg::FW-1:0] qy,
	output logic signed [rmq_pkg::FW-1:0] qz,
	output logic signed [rmq_pkg::FW-1:0] qw,
	output logic [1:0] branch_taken,
	output logic degenerate
);
	logic front_v, fifo_full, fifo_empty;
	rmq_pkg::front_t front_d, fifo_d;

	assign busy = fifo_full;

	rmq_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.m11(m11), .m12(m12), .m13(m13),
		.m21(m21), .m22(m22), .m23(m23),
		.m31(m31), .m32(m32), .m33(m33),
		.out_v(front_v), .out_d(front_d)
	);

	rmq_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(front_v), .in_d(front_d),
		.pop(!fifo_empty),
		.full(fifo_full), .empty(fifo_empty), .out_d(fifo_d)
	);

	rmq_back u_back (
		.clk(clk), .arst_n(arst_n),
		.in_v(!fifo_empty), .in_d(fifo_d),
		.done(done), .qx(qx), .qy(qy), .qz(qz), .qw(qw),
		.branch_taken(branch_taken), .degenerate(degenerate)
	);

	`RMQ_NEVER(a_no_overrun, fifo_full && front_v)
	`RMQ_ASSERT(a_latency, done == $past(start && !busy && arst_n, rmq_pkg::LATENCY))
	`RMQ_ASSERT(a_degen_zero, done && degenerate |-> qx == '0 && qy == '0 && qz == '0 && qw == '0)
	`RMQ_ASSERT(a_trace_ok, done && branch_taken == rmq_pkg::BR_TRACE |-> !degenerate)
endmodule
